@@ hw/rtl/dtsd_pkg.sv @@
`default_nettype none

package dtsd_pkg;

   // One incoming date and time of day.
   typedef struct packed {
      logic [13:0] year_value;
      logic [3:0]  month_value;
      logic [4:0]  day_value;
      logic [4:0]  hour_value;
      logic [5:0]  minute_value;
      logic [15:0] second_ms;
   } req_type;

   // One converted result.
   typedef struct packed {
      logic [21:0] serial_day;
      logic [31:0] day_fraction;
      logic        range_error;
   } rsp_type;

   // Epoch years and the special dates of the 1900 system.
   localparam logic [13:0] Year1900      = 14'd1900;
   localparam logic [13:0] Year1904      = 14'd1904;
   localparam logic [13:0] YearBefore    = 14'd1899;
   localparam logic [14:0] Epoch1904Skew = 15'd4;
   localparam logic [15:0] QuadCentSkew  = 16'd300;
   localparam logic [8:0]  DaysPerYear   = 9'd365;
   localparam logic [22:0] LastTrueDay   = 23'd59;
   localparam logic [23:0] FalseLeapDay  = 24'd60;
   localparam logic [21:0] SerialMax     = 22'h3FFFFF;

   // Time of day in milliseconds.
   localparam logic [26:0] MsPerHour   = 27'd3600000;
   localparam logic [26:0] MsPerMinute = 27'd60000;
   localparam logic [26:0] MsPerDay    = 27'd86400000;

   // Division by 100 for values below 43699: (x * 5243) >> 19.
   localparam logic [12:0] Div100Mul   = 13'd5243;
   localparam int          Div100Shift = 19;

   // Fraction: floor(rem * 2^32 / 86400000) = floor(rem * 2^22 / 84375).
   // The estimate (rem * FracRecip) >> 26 is at most two below the quotient.
   localparam logic [17:0] FracDivisor  = 18'd84375;
   localparam logic [17:0] FracDivisor2 = 18'd168750;
   localparam logic [31:0] FracRecip    = 32'((64'd1 << 48) / 64'd84375);
   localparam int          FracShift    = 26;

   // Days in the year before the first of each month (index 1 to 12).
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/date_to_serial_day_top.sv @@
`default_nettype none

// Converts a calendar date and time of day into a spreadsheet serial day number
// and an unsigned Q0.32 fraction of the day, in the 1900 or the 1904 epoch as
// set by csr_wr_data. One transaction is taken in every cycle while req_stall is
// low; a result reaches rsp through the five register stages (time sum, constant
// divisions, day sum with the fraction reciprocal multiply, day adjustment with
// the back multiply, fraction correction into the output register). A stalled
// output fills empty stages first, so req_stall rises only once every stage
// holds a transaction. The epoch register is read by several stages and is
// meant to be written while the pipeline is empty.
module date_to_serial_day_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  dtsd_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output dtsd_pkg::rsp_type      rsp_data,
   input  wire                    csr_wr_en,
   input  wire                    csr_wr_data
);

   typedef struct packed {
      logic [26:0] ms;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] span;
      logic [14:0] span_skew;
      logic        special_zero;
      logic        special_leap;
      logic        before_epoch;
   } s1_type;

   typedef struct packed {
      logic        carry;
      logic [26:0] rem;
      logic [13:0] year;
      logic [7:0]  year_cent;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] span;
      logic [7:0]  cent_count;
      logic [5:0]  quad_cent_count;
      logic        special_zero;
      logic        special_leap;
      logic        before_epoch;
   } s2_type;

   typedef struct packed {
      logic        carry;
      logic [31:0] frac_est;
      logic [23:0] days;
      logic        special_zero;
      logic        special_leap;
      logic        before_epoch;
   } s3_type;

   typedef struct packed {
      logic [31:0] frac_est;
      logic [17:0] frac_prod;
      logic [21:0] serial;
      logic        error;
   } s4_type;

   localparam logic [17:0] FracResidueLimit = 18'd253125;

   logic              epoch_ff;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   s3_type            s3_ff, s3_in;
   s4_type            s4_ff, s4_in;
   dtsd_pkg::rsp_type rsp_ff, rsp_in;
   logic              s1_ready, s2_ready, s3_ready, s4_ready, rsp_ready;

   // Each stage loads when it is empty or its contents move on.
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Stage 1: time in milliseconds, date substitution and epoch checks.
   always_comb begin
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] epoch_year;
      year  = req_data.year_value;
      month = req_data.month_value;
      day   = req_data.day_value;
      if (year == 14'd0) begin
         if (!epoch_ff) begin
            year  = dtsd_pkg::YearBefore;
            month = 4'd12;
            day   = 5'd31;
         end else begin
            year  = dtsd_pkg::Year1904;
            month = 4'd1;
            day   = 5'd1;
         end
      end
      epoch_year = epoch_ff ? dtsd_pkg::Year1904 : dtsd_pkg::Year1900;

      s1_in.ms = 27'(req_data.hour_value) * dtsd_pkg::MsPerHour
               + 27'(req_data.minute_value) * dtsd_pkg::MsPerMinute
               + 27'(req_data.second_ms);
      s1_in.year  = year;
      s1_in.month = (month > 4'd12) ? 4'd12 : month;
      s1_in.day   = day;
      s1_in.span  = year - epoch_year;
      s1_in.span_skew = 15'(year - epoch_year)
                      + (epoch_ff ? dtsd_pkg::Epoch1904Skew : 15'd0);
      s1_in.special_zero = !epoch_ff &&
         ((year == dtsd_pkg::YearBefore && month == 4'd12 && day == 5'd31) ||
          (year == dtsd_pkg::Year1900 && month == 4'd1 && day == 5'd0));
      s1_in.special_leap = !epoch_ff && !s1_in.special_zero &&
         year == dtsd_pkg::Year1900 && month == 4'd2 && day == 5'd29;
      s1_in.before_epoch = !s1_in.special_zero && !s1_in.special_leap &&
         (year < epoch_year);
   end

   // Stage 2: whole-day carry out of the time, and the divisions by 100 and 400.
   always_comb begin
      logic [26:0] year_prod;
      logic [27:0] cent_prod;
      logic [11:0] quad_arg;
      logic [24:0] quad_prod;
      year_prod = 27'(s1_ff.year) * 27'(dtsd_pkg::Div100Mul);
      cent_prod = 28'(s1_ff.span_skew) * 28'(dtsd_pkg::Div100Mul);
      quad_arg  = 12'((16'(s1_ff.span_skew) + dtsd_pkg::QuadCentSkew) >> 2);
      quad_prod = 25'(quad_arg) * 25'(dtsd_pkg::Div100Mul);

      s2_in.carry = (s1_ff.ms >= dtsd_pkg::MsPerDay);
      s2_in.rem   = s2_in.carry ? (s1_ff.ms - dtsd_pkg::MsPerDay) : s1_ff.ms;
      s2_in.year  = s1_ff.year;
      s2_in.year_cent = year_prod[dtsd_pkg::Div100Shift +: 8];
      s2_in.month = s1_ff.month;
      s2_in.day   = s1_ff.day;
      s2_in.span  = s1_ff.span;
      s2_in.cent_count      = cent_prod[dtsd_pkg::Div100Shift +: 8];
      s2_in.quad_cent_count = quad_prod[dtsd_pkg::Div100Shift +: 6];
      s2_in.special_zero = s1_ff.special_zero;
      s2_in.special_leap = s1_ff.special_leap;
      s2_in.before_epoch = s1_ff.before_epoch;
   end

   // Stage 3: leap year, day sum, and the reciprocal estimate of the fraction.
   always_comb begin
      logic [13:0] cent_rem;
      logic        leap;
      logic [58:0] frac_prod;
      cent_rem = s2_ff.year - 14'(15'(s2_ff.year_cent) * 15'd100);
      leap = (s2_ff.year[1:0] == 2'd0) &&
             ((cent_rem != 14'd0) || (s2_ff.year_cent[1:0] == 2'd0));
      frac_prod = 59'(s2_ff.rem) * 59'(dtsd_pkg::FracRecip);

      s3_in.carry    = s2_ff.carry;
      s3_in.frac_est = frac_prod[dtsd_pkg::FracShift +: 32];
      s3_in.days = 24'(dtsd_pkg::days_before_month(s2_ff.month))
                 + 24'(leap && (s2_ff.month > 4'd2))
                 + 24'(s2_ff.day)
                 + 24'(s2_ff.span) * 24'(dtsd_pkg::DaysPerYear)
                 + 24'(s2_ff.span[13:2])
                 + 24'(s2_ff.quad_cent_count)
                 - 24'(s2_ff.cent_count)
                 - 24'(leap);
      s3_in.special_zero = s2_ff.special_zero;
      s3_in.special_leap = s2_ff.special_leap;
      s3_in.before_epoch = s2_ff.before_epoch;
   end

   // Stage 4: false leap day shift, carry, saturation, and the back multiply.
   always_comb begin
      logic [23:0] days_adj;
      logic [23:0] days_base;
      logic [23:0] days_total;
      days_adj = s3_ff.days;
      if (!epoch_ff && !s3_ff.days[23] && (s3_ff.days[22:0] > dtsd_pkg::LastTrueDay)) begin
         days_adj = s3_ff.days + 24'd1;
      end
      if (s3_ff.special_zero) begin
         days_base = 24'd0;
      end else if (s3_ff.special_leap) begin
         days_base = dtsd_pkg::FalseLeapDay;
      end else begin
         days_base = days_adj;
      end
      days_total = days_base + 24'(s3_ff.carry);

      s4_in.error = s3_ff.before_epoch || days_total[23];
      if (s4_in.error) begin
         s4_in.serial = 22'd0;
      end else if (days_total[22]) begin
         s4_in.serial = dtsd_pkg::SerialMax;
      end else begin
         s4_in.serial = days_total[21:0];
      end
      s4_in.frac_est  = s3_ff.frac_est;
      s4_in.frac_prod = 18'(s3_ff.frac_est[17:0]) * dtsd_pkg::FracDivisor;
   end

   // Stage 5: the residue of the estimate lifts it by up to two.
   logic [17:0] frac_residue;
   assign frac_residue = 18'd0 - s4_ff.frac_prod;

   always_comb begin
      logic [31:0] frac;
      frac = s4_ff.frac_est
           + 32'(frac_residue >= dtsd_pkg::FracDivisor)
           + 32'(frac_residue >= dtsd_pkg::FracDivisor2);
      rsp_in.serial_day   = s4_ff.serial;
      rsp_in.day_fraction = s4_ff.error ? 32'd0 : frac;
      rsp_in.range_error  = s4_ff.error;
   end

   // Control state and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            epoch_ff <= csr_wr_data;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      if (s4_ready) begin
         s4_ff <= s4_in;
      end
      if (rsp_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   // The output is empty straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   // Requests are held off only when every stage is occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff &&
                     rsp_valid_ff))
      else $error("request stalled with a bubble in the pipeline");

   // The reciprocal estimate never falls more than two below the quotient.
   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (frac_residue < FracResidueLimit))
      else $error("fraction residue out of range");

   // An out-of-range transaction carries zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.range_error) |->
         (rsp_ff.serial_day == 22'd0 && rsp_ff.day_fraction == 32'd0))
      else $error("range error with non-zero result");

endmodule

`default_nettype wire

@@ dv/date_to_serial_day_top_tb.sv @@
`timescale 1ns / 100ps

module date_to_serial_day_top_tb;

   localparam logic        EPOCH_1900       = 1'b0;
   localparam logic        EPOCH_1904       = 1'b1;
   localparam longint      MS_IN_DAY        = 64'd86400000;
   localparam longint      SERIAL_CEIL      = 64'd4194303;
   localparam int unsigned RANDOM_PER_PHASE = 430;
   localparam int unsigned LONG_HOLD_AT     = 120;
   localparam int unsigned LONG_HOLD_CYCLES = 150;
   localparam int unsigned IDLE_LIMIT       = 2000;
   localparam int unsigned SETTLE_CYCLES    = 20;
   localparam int unsigned REPORT_LIMIT     = 10;

   // What the sender does next: offer a date, change the epoch, or wait for the pipeline to empty.
   typedef enum logic [1:0] {STEP_DATE, STEP_SET_EPOCH, STEP_DRAIN} step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      dtsd_pkg::req_type date;
      logic              epoch;
   } date_step_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   dtsd_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   dtsd_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;

   date_step_type     pending_dates[$];
   dtsd_pkg::rsp_type expected_serials[$];
   logic              epoch_now      = EPOCH_1900;
   int unsigned       sent_total     = 0;
   int unsigned       got_total      = 0;
   int unsigned       mismatch_total = 0;
   int unsigned       send_gap       = 0;
   int unsigned       stall_left     = 0;
   int unsigned       idle_cycles    = 0;
   logic              long_hold_done = 1'b0;

   date_to_serial_day_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Gregorian leap year rule.
   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // Serial day and Q0.32 day fraction for one date in the given epoch.
   function automatic dtsd_pkg::rsp_type serial_of_date(input dtsd_pkg::req_type d,
                                                        input logic in_1904);
      longint unsigned   ms_of_day;
      longint unsigned   ms_left;
      longint unsigned   frac_q32;
      longint            day_count;
      longint            day_carry;
      int unsigned       yr;
      int unsigned       mon;
      int unsigned       dom;
      int unsigned       span;
      int unsigned       base_year;
      int unsigned       skew;
      int unsigned       leap;
      bit                err;
      bit                special;
      dtsd_pkg::rsp_type r;
      ms_of_day = longint'(d.hour_value) * 64'd3600000 + longint'(d.minute_value) * 64'd60000
                  + longint'(d.second_ms);
      day_carry = longint'(ms_of_day / MS_IN_DAY);
      ms_left   = ms_of_day % MS_IN_DAY;
      frac_q32  = (ms_left << 32) / MS_IN_DAY;
      yr        = d.year_value;
      mon       = d.month_value;
      dom       = d.day_value;
      base_year = in_1904 ? 1904 : 1900;
      skew      = in_1904 ? 4 : 0;
      err       = 1'b0;
      special   = 1'b0;
      day_count = 0;

      // A time with no date sits on the epoch's day zero.
      if (yr == 0) begin
         if (!in_1904) begin
            yr  = 1899;
            mon = 12;
            dom = 31;
         end else begin
            yr  = 1904;
            mon = 1;
            dom = 1;
         end
      end

      // The 1900 system has two names for day zero and a leap day that never was.
      if (!in_1904 && ((yr == 1899 && mon == 12 && dom == 31) ||
                       (yr == 1900 && mon == 1 && dom == 0))) begin
         special = 1'b1;
      end else if (!in_1904 && yr == 1900 && mon == 2 && dom == 29) begin
         day_count = 60;
         special   = 1'b1;
      end else if (yr < base_year) begin
         err = 1'b1;
      end

      if (!special && !err) begin
         span = yr - base_year;
         if (mon > 12) begin
            mon = 12;
         end
         leap = leap_year(yr) ? 1 : 0;
         case (mon)
            2:       day_count = 31;
            3:       day_count = 59;
            4:       day_count = 90;
            5:       day_count = 120;
            6:       day_count = 151;
            7:       day_count = 181;
            8:       day_count = 212;
            9:       day_count = 243;
            10:      day_count = 273;
            11:      day_count = 304;
            12:      day_count = 334;
            default: day_count = 0;
         endcase
         if (leap != 0 && mon > 2) begin
            day_count = day_count + 1;
         end
         day_count = day_count + longint'(dom);
         day_count = day_count + longint'(span) * 365;
         day_count = day_count + longint'(span / 4);
         day_count = day_count - longint'((span + skew) / 100);
         day_count = day_count + longint'((span + skew + 300) / 400);
         day_count = day_count - longint'(leap);
         // Every day after the false leap day moves up by one.
         if (!in_1904 && day_count > 59) begin
            day_count = day_count + 1;
         end
      end

      day_count = day_count + day_carry;
      if (!err && day_count < 0) begin
         err = 1'b1;
      end

      if (err) begin
         r.serial_day   = '0;
         r.day_fraction = '0;
         r.range_error  = 1'b1;
      end else begin
         if (day_count > SERIAL_CEIL) begin
            day_count = SERIAL_CEIL;
         end
         r.serial_day   = day_count[21:0];
         r.day_fraction = frac_q32[31:0];
         r.range_error  = 1'b0;
      end
      return r;
   endfunction

   task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d,
                           input int unsigned h, input int unsigned mi, input int unsigned ms);
      date_step_type s;
      s.kind              = STEP_DATE;
      s.epoch             = 1'b0;
      s.date.year_value   = 14'(y);
      s.date.month_value  = 4'(m);
      s.date.day_value    = 5'(d);
      s.date.hour_value   = 5'(h);
      s.date.minute_value = 6'(mi);
      s.date.second_ms    = 16'(ms);
      pending_dates.insert(pending_dates.size(), s);
   endtask

   task automatic add_marker(input step_kind_type kind, input logic epoch);
      date_step_type s;
      s.kind  = kind;
      s.date  = '0;
      s.epoch = epoch;
      pending_dates.insert(pending_dates.size(), s);
   endtask

   // Mostly valid dates around the epoch, with a share of edge dates, overflowing times and noise.
   function automatic dtsd_pkg::req_type random_date(input logic in_1904);
      dtsd_pkg::req_type d;
      int unsigned       pick;
      pick           = $urandom_range(0, 99);
      d.year_value   = 14'($urandom_range(in_1904 ? 1904 : 1900, 2200));
      d.month_value  = 4'($urandom_range(1, 12));
      d.day_value    = 5'($urandom_range(1, 28));
      d.hour_value   = 5'($urandom_range(0, 23));
      d.minute_value = 6'($urandom_range(0, 59));
      d.second_ms    = 16'($urandom_range(0, 59999));
      if (pick < 12) begin
         d.year_value = 14'($urandom_range(1, 9999));
      end else if (pick < 17) begin
         d.year_value  = '0;
         d.month_value = 4'($urandom);
         d.day_value   = 5'($urandom);
      end else if (pick < 28) begin
         case ($urandom_range(0, 4))
            0:       d.year_value = 14'd1899;
            1:       d.year_value = 14'd1900;
            2:       d.year_value = 14'd1903;
            3:       d.year_value = 14'd1904;
            default: d.year_value = 14'd1905;
         endcase
         d.month_value = ($urandom_range(0, 3) == 0) ? 4'd12 : 4'($urandom_range(1, 3));
         d.day_value   = 5'($urandom_range(0, 31));
      end else if (pick < 35) begin
         d.day_value = 5'($urandom_range(29, 31));
      end else if (pick < 42) begin
         d.hour_value   = 5'($urandom);
         d.minute_value = 6'($urandom);
         d.second_ms    = 16'($urandom);
      end else if (pick < 50) begin
         d.year_value   = 14'($urandom);
         d.month_value  = 4'($urandom);
         d.day_value    = 5'($urandom);
         d.hour_value   = 5'($urandom);
         d.minute_value = 6'($urandom);
         d.second_ms    = 16'($urandom);
      end
      return d;
   endfunction

   // Sender gaps: calm stretches, otherwise mostly short with the odd long one.
   function automatic int unsigned pick_send_gap(input int unsigned n);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if ((n / 150) % 4 == 1 || roll < 55) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Sender: presents dates in order, changes the epoch only once the pipeline has emptied.
   always @(posedge clock) begin : feed_dates
      logic write_now;
      write_now = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_serials.insert(expected_serials.size(),
                                    serial_of_date(req_data, epoch_now));
            sent_total <= sent_total + 1;
         end
         if (req_valid && req_stall) begin
            // A stalled transaction stays exactly as it is.
         end else if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_dates.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_dates[0].kind == STEP_DATE) begin
            req_valid <= 1'b1;
            req_data  <= pending_dates[0].date;
            void'(pending_dates.pop_front());
            send_gap  <= pick_send_gap(sent_total);
         end else begin
            req_valid <= 1'b0;
            if (!req_valid && sent_total == got_total) begin
               if (pending_dates[0].kind == STEP_SET_EPOCH) begin
                  write_now = 1'b1;
                  csr_wr_data <= pending_dates[0].epoch;
                  epoch_now   <= pending_dates[0].epoch;
                  send_gap    <= 1;
               end
               void'(pending_dates.pop_front());
            end
         end
      end
      csr_wr_en <= write_now;
   end

   // Receiver stalls: one long hold early on so the pipeline backs up, then random ones.
   always @(posedge clock) begin : pace_results
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (!long_hold_done && got_total >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         rsp_stall      <= 1'b1;
         stall_left     <= LONG_HOLD_CYCLES;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ((got_total / 150) % 4 == 2 || roll < 65) begin
         rsp_stall <= 1'b0;
      end else if (roll < 95) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(8, 40);
      end
   end

   // Each result transaction is checked against the oldest prediction.
   always @(posedge clock) begin : check_results
      dtsd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_total <= got_total + 1;
         if (expected_serials.size() == 0) begin
            mismatch_total = mismatch_total + 1;
            if (mismatch_total <= REPORT_LIMIT) begin
               $display("unexpected result: serial_day %0d day_fraction %h range_error %0b",
                        rsp_data.serial_day, rsp_data.day_fraction, rsp_data.range_error);
            end
         end else begin
            want = expected_serials.pop_front();
            if (rsp_data.serial_day !== want.serial_day ||
                rsp_data.day_fraction !== want.day_fraction ||
                rsp_data.range_error !== want.range_error) begin
               mismatch_total = mismatch_total + 1;
               if (mismatch_total <= REPORT_LIMIT) begin
                  $display({"mismatch on result %0d: serial_day %0d/%0d",
                            " day_fraction %h/%h %s %0b/%0b"},
                           got_total, want.serial_day, rsp_data.serial_day,
                           want.day_fraction, rsp_data.day_fraction, "range_error",
                           want.range_error, rsp_data.range_error);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      // Directed dates in the 1900 system: day zero, the false leap day and its neighbours.
      add_date(0, 0, 0, 0, 0, 0);
      add_date(0, 0, 0, 23, 59, 59999);
      add_date(1899, 12, 31, 12, 0, 0);
      add_date(1900, 1, 0, 6, 0, 0);
      add_date(1900, 1, 1, 0, 0, 0);
      add_date(1900, 2, 28, 0, 0, 0);
      add_date(1900, 2, 29, 18, 30, 30000);
      add_date(1900, 3, 1, 0, 0, 1);
      add_date(1899, 12, 30, 0, 0, 0);
      add_date(1, 1, 1, 0, 0, 0);
      add_date(9999, 12, 31, 23, 59, 59999);
      add_date(16383, 15, 31, 31, 63, 65535);
      add_date(2000, 2, 29, 0, 0, 0);
      add_date(2023, 2, 31, 0, 0, 0);
      add_date(2100, 3, 1, 0, 0, 0);

      // Directed dates in the 1904 system, including a negative day pulled back by a carried day.
      add_marker(STEP_SET_EPOCH, EPOCH_1904);
      add_date(0, 5, 17, 12, 0, 0);
      add_date(1904, 1, 1, 0, 0, 0);
      add_date(1904, 1, 0, 0, 0, 0);
      add_date(1904, 1, 0, 24, 0, 0);
      add_date(1903, 12, 31, 0, 0, 0);
      add_date(1900, 2, 29, 0, 0, 0);
      add_date(1899, 12, 31, 0, 0, 0);
      add_date(9999, 12, 31, 23, 59, 59999);
      add_date(16383, 12, 31, 0, 0, 0);
      add_date(2000, 3, 1, 0, 0, 0);

      // Random phases, alternating the epoch, each with a pause for a full drain part way.
      for (int p = 0; p < 4; p++) begin
         add_marker(STEP_SET_EPOCH, (p % 2 == 0) ? EPOCH_1900 : EPOCH_1904);
         for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) begin
            date_step_type s;
            s.kind  = STEP_DATE;
            s.epoch = 1'b0;
            s.date  = random_date((p % 2 == 0) ? EPOCH_1900 : EPOCH_1904);
            pending_dates.insert(pending_dates.size(), s);
            if (i == RANDOM_PER_PHASE / 2) begin
               add_marker(STEP_DRAIN, 1'b0);
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_dates.size() != 0 || req_valid || sent_total != got_total) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_serials.size() != 0) begin
         $display("%0d results never arrived", expected_serials.size());
         mismatch_total = mismatch_total + expected_serials.size();
      end
      if (mismatch_total == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
